FILE: design/diode_ladder_lowpass_filter_top_assert.svh
// Assertion macros for the diode ladder low-pass filter top level.
`ifndef DIODE_LADDER_LOWPASS_FILTER_TOP_ASSERT_SVH
`define DIODE_LADDER_LOWPASS_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DLLPF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dllpf: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DLLPF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dllpf: assertion failed");

`endif

FILE: design/dllpf_pkg.sv
// Shared types, constants and table functions of the ladder filter.
package dllpf_pkg;

	localparam int SAMPLE_WIDTH_DEF     = 16;
	localparam int STATE_WIDTH_DEF      = 24;
	localparam int TANH_TABLE_DEPTH_DEF = 256;

	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STAGE_G  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE    = 2'd3;

	localparam logic        BYPASS_RST   = 1'b1;
	localparam logic [15:0] STAGE_G_RST  = 16'hFFFF;
	localparam logic [16:0] FEEDBACK_RST = 17'd0;
	localparam logic [14:0] DRIVE_RST    = 15'd4096;

	// stage counter: four poles, parked on the last one between requests
	localparam logic [1:0] STG_FIRST = 2'd0;
	localparam logic [1:0] STG_LAST  = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DRIVE,
		ST_FDBK,
		ST_SUB,
		ST_MAG,
		ST_POS,
		ST_IDX,
		ST_LO,
		ST_HI,
		ST_INTERP,
		ST_Y,
		ST_STG_SUB,
		ST_STG_MUL,
		ST_STG_UPD,
		ST_OUT
	} state_t;

	typedef struct packed {
		state_t     st;
		logic [1:0] stg;
		logic       ready;
		logic       out_load;
	} ctrl_t;

	// Restoring division; only evaluated while building the constant table.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Entry j of tanh over [0,4] in 'half' segments, 'frac' fractional bits.
	// r = exp(-8/half) from a truncated series, e = r^j in rounded Q0.30.
	function automatic logic [63:0] tanh_entry(input int j, input int half, input int frac);
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		logic [63:0] e;
		logic [63:0] num;
		logic [63:0] den;
		term = 64'd1 << 60;
		sum  = term;
		for (int k = 1; k <= 20; k++) begin
			term = udiv64(term * 64'd8, 64'(half) * 64'(k));
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		r = (sum + (64'd1 << 29)) >> 30;
		e = 64'd1 << 30;
		for (int i = 0; i < j; i++)
			e = (e * r + (64'd1 << 29)) >> 30;
		num = ((64'd1 << 30) - e) << frac;
		den = (64'd1 << 30) + e;
		return udiv64(num + (den >> 1), den);
	endfunction

endpackage

FILE: design/dllpf_mul.sv
// Shared signed multiplier with a registered product.
module dllpf_mul
	import dllpf_pkg::*;
#(
	parameter int A_W = 25,
	parameter int B_W = 23
) (
	input  logic                     clk,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [B_W-1:0]    b,
	output logic signed [A_W+B_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

FILE: design/dllpf_tanh_rom.sv
// Constant tanh table over [0,4] with a registered read port.
module dllpf_tanh_rom
	import dllpf_pkg::*;
#(
	parameter int HALF = 128,
	parameter int FB   = 20
) (
	input  logic                      clk,
	input  logic [$clog2(HALF+1)-1:0] addr,
	output logic [FB-1:0]             rd_q
);

	logic [FB-1:0] tbl [HALF+1];

	for (genvar gj = 0; gj <= HALF; gj++) begin : g_tbl
		localparam logic [63:0] ENT = tanh_entry(gj, HALF, FB);
		assign tbl[gj] = ENT[FB-1:0];
	end

	always_ff @(posedge clk) begin
		rd_q <= tbl[addr];
	end

endmodule

FILE: design/dllpf_ctrl.sv
// Sequencer of the ladder filter: one request walks through all steps, or straight to output in bypass.
module dllpf_ctrl
	import dllpf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	input  logic  bypass,
	input  logic  out_free,
	output ctrl_t ctl
);

	state_t     st_q, st_d;
	logic [1:0] stg_q, stg_d;
	logic       out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			stg_q <= STG_LAST;
		end else begin
			st_q  <= st_d;
			stg_q <= stg_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		stg_d    = stg_q;
		out_load = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (in_fire)
					st_d = bypass ? ST_OUT : ST_DRIVE;
			end
			ST_DRIVE:   st_d = ST_FDBK;
			ST_FDBK:    st_d = ST_SUB;
			ST_SUB:     st_d = ST_MAG;
			ST_MAG:     st_d = ST_POS;
			ST_POS:     st_d = ST_IDX;
			ST_IDX:     st_d = ST_LO;
			ST_LO:      st_d = ST_HI;
			ST_HI:      st_d = ST_INTERP;
			ST_INTERP:  st_d = ST_Y;
			ST_Y: begin
				st_d  = ST_STG_SUB;
				stg_d = STG_FIRST;
			end
			ST_STG_SUB: st_d = ST_STG_MUL;
			ST_STG_MUL: st_d = ST_STG_UPD;
			ST_STG_UPD: begin
				if (stg_q == STG_LAST) begin
					st_d = ST_OUT;
				end else begin
					stg_d = stg_q + 2'd1;
					st_d  = ST_STG_SUB;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign ctl.st       = st_q;
	assign ctl.stg      = stg_q;
	assign ctl.ready    = (st_q == ST_IDLE);
	assign ctl.out_load = out_load;

endmodule

FILE: design/diode_ladder_lowpass_filter_top.sv
// Top level of the four-pole diode ladder low-pass filter.
// A request steps through drive, feedback, tanh lookup and interpolation, then the
// shared multiplier and table port are used in series by the sequencer, four poles
// in turn. Bypass goes straight to output; a new sample waits for the result load.
// Reset clears stage states and config to their defaults (bypass on).
// A waiting result is held in the output register while the next request is taken.
`include "diode_ladder_lowpass_filter_top_assert.svh"

module diode_ladder_lowpass_filter_top
	import dllpf_pkg::*;
#(
	parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
	parameter int STATE_WIDTH      = STATE_WIDTH_DEF,
	parameter int TANH_TABLE_DEPTH = TANH_TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // sample_in
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,  // sample_out
	input  logic                                cfg_we,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [CFG_DATA_W-1:0]               cfg_wdata
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int TW     = STATE_WIDTH;
	localparam int FB     = TW - 4;
	localparam int HALF   = TANH_TABLE_DEPTH / 2;
	localparam int AW     = $clog2(HALF + 1);
	localparam int DATA_W = ((SW + 7) / 8) * 8;
	localparam int MA0    = (TW + 1 > SW) ? TW + 1 : SW;
	localparam int MA     = (MA0 > 18) ? MA0 : 18;
	localparam int MB     = (FB + 3 > 18) ? FB + 3 : 18;
	localparam int PW     = MA + MB;
	localparam int U_W    = ((SW > TW + 2) ? SW : TW + 2) + 17;
	localparam int UIN_L  = (FB + 1 > SW) ? FB + 1 - SW : 0;
	localparam int UIN_R  = (SW > FB + 1) ? SW - 1 - FB : 0;
	localparam int OSH_R  = (FB > SW - 1) ? FB - SW + 1 : 0;
	localparam int OSH_L  = (SW - 1 > FB) ? SW - 1 - FB : 0;
	localparam int O_W    = TW + 1 + OSH_L;
	localparam logic [63:0] TANH_TOP_E = tanh_entry(HALF, HALF, FB);

	ctrl_t ctl;
	logic  in_fire;
	logic  out_free;

	// configuration
	logic        bypass_q;
	logic [15:0] stage_gain_q;
	logic [16:0] feedback_gain_q;
	logic [14:0] drive_gain_q;

	// stage states
	logic signed [TW-1:0] st_q [4];
	logic signed [TW-1:0] st_cur;

	// datapath registers
	logic signed [SW-1:0]  x_q;
	logic                  byp_q;
	logic signed [U_W-1:0] uin_q;
	logic signed [U_W-1:0] u_q;
	logic [FB+1:0]         mag_q;
	logic                  neg_q;
	logic                  sat_q;
	logic [AW-1:0]         idx_q;
	logic [FB+1:0]         fr_q;
	logic [FB-1:0]         lo_q;
	logic signed [FB:0]    diff_q;
	logic signed [TW:0]    sig_q;
	logic signed [TW:0]    dif_q;
	logic                  out_valid_q;
	logic [SW-1:0]         out_data_q;

	// shared units
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PW-1:0] prod_q;
	logic [AW-1:0]        rom_addr;
	logic [FB-1:0]        rom_q;

	// combinational helpers
	logic signed [U_W-1:0] t_prod;
	logic [U_W-1:0]        u_abs;
	logic [U_W-13:0]       mag_all;
	logic signed [PW-1:0]  step_w;
	logic signed [FB+1:0]  y_val;
	logic signed [PW-1:0]  v_w;
	logic signed [TW:0]    v_val;
	logic signed [TW:0]    lp_val;
	logic signed [TW+1:0]  snew;
	logic signed [TW-1:0]  snew_sat;
	logic signed [O_W-1:0] o_wide;
	logic [SW-1:0]         o_sat;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = ctl.ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DATA_W'(out_data_q);

	dllpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.bypass   (bypass_q),
		.out_free (out_free),
		.ctl      (ctl)
	);

	dllpf_mul #(
		.A_W (MA),
		.B_W (MB)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	dllpf_tanh_rom #(
		.HALF (HALF),
		.FB   (FB)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.rd_q (rom_q)
	);

	// feedback reads stage 3: the counter is parked there outside the pole loop
	assign st_cur = st_q[ctl.stg];

	always_comb begin
		unique case (ctl.st)
			ST_DRIVE: begin
				mul_a = MA'(x_q);
				mul_b = MB'(drive_gain_q);
			end
			ST_FDBK: begin
				mul_a = MA'(st_cur);
				mul_b = MB'(feedback_gain_q);
			end
			ST_POS: begin
				mul_a = MA'(mag_q);
				mul_b = MB'(HALF);
			end
			ST_INTERP: begin
				mul_a = MA'(diff_q);
				mul_b = MB'(fr_q);
			end
			default: begin
				mul_a = MA'(dif_q);
				mul_b = MB'(stage_gain_q);
			end
		endcase
	end

	always_comb begin
		unique case (ctl.st)
			ST_IDX:  rom_addr = prod_q[FB+2 +: AW];
			ST_LO:   rom_addr = idx_q + AW'(1);
			default: rom_addr = idx_q;
		endcase
	end

	assign t_prod  = U_W'(prod_q);
	assign u_abs   = u_q[U_W-1] ? U_W'(-u_q) : U_W'(u_q);
	assign mag_all = u_abs[U_W-1:12];

	// interpolation step, floored
	assign step_w = prod_q >>> (FB + 2);
	always_comb begin
		if (sat_q)
			y_val = $signed({2'b00, TANH_TOP_E[FB-1:0]});
		else
			y_val = $signed({2'b00, lo_q}) + $signed(step_w[FB+1:0]);
	end

	// one trapezoidal pole
	assign v_w    = prod_q >>> 16;
	assign v_val  = $signed(v_w[TW:0]);
	assign lp_val = (TW+1)'(st_cur) + v_val;
	assign snew   = (TW+2)'(lp_val) + (TW+2)'(v_val);
	always_comb begin
		if (snew[TW+1:TW-1] == 3'b000 || snew[TW+1:TW-1] == 3'b111)
			snew_sat = snew[TW-1:0];
		else if (snew[TW+1])
			snew_sat = {1'b1, {(TW-1){1'b0}}};
		else
			snew_sat = {1'b0, {(TW-1){1'b1}}};
	end

	// output format: fourth pole to sample width, saturated
	assign o_wide = (O_W'(sig_q) <<< OSH_L) >>> OSH_R;
	always_comb begin
		if (&o_wide[O_W-1:SW-1] || ~|o_wide[O_W-1:SW-1])
			o_sat = o_wide[SW-1:0];
		else if (o_wide[O_W-1])
			o_sat = {1'b1, {(SW-1){1'b0}}};
		else
			o_sat = {1'b0, {(SW-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q        <= BYPASS_RST;
			stage_gain_q    <= STAGE_G_RST;
			feedback_gain_q <= FEEDBACK_RST;
			drive_gain_q    <= DRIVE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BYPASS:   bypass_q        <= cfg_wdata[0];
				CFG_STAGE_G:  stage_gain_q    <= cfg_wdata[15:0];
				CFG_FEEDBACK: feedback_gain_q <= cfg_wdata[16:0];
				CFG_DRIVE:    drive_gain_q    <= cfg_wdata[14:0];
				default:      bypass_q        <= bypass_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				st_q[i] <= '0;
		end else if (ctl.st == ST_STG_UPD) begin
			st_q[ctl.stg] <= snew_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q   <= s_axis_tdata[SW-1:0];
			byp_q <= bypass_q;
		end
		if (ctl.out_load)
			out_data_q <= byp_q ? x_q : o_sat;
		unique case (ctl.st)
			ST_FDBK: uin_q <= (t_prod <<< UIN_L) >>> UIN_R;
			ST_SUB:  u_q   <= uin_q - t_prod;
			ST_MAG: begin
				neg_q <= u_q[U_W-1];
				sat_q <= |mag_all[U_W-13:FB+2];
				mag_q <= mag_all[FB+1:0];
			end
			ST_IDX: begin
				idx_q <= prod_q[FB+2 +: AW];
				fr_q  <= prod_q[FB+1:0];
			end
			ST_LO:      lo_q   <= rom_q;
			ST_HI:      diff_q <= $signed({1'b0, rom_q}) - $signed({1'b0, lo_q});
			ST_Y:       sig_q  <= neg_q ? -(TW+1)'(y_val) : (TW+1)'(y_val);
			ST_STG_SUB: dif_q  <= sig_q - (TW+1)'(st_cur);
			ST_STG_UPD: sig_q  <= lp_val;
			default: ;
		endcase
	end

	`DLLPF_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`DLLPF_ASSERT_IMPL(a_idle_stg_parked, s_axis_tready, ctl.stg == STG_LAST)
	`DLLPF_ASSERT_NEXT(a_state_hold, ctl.st != ST_STG_UPD, $stable(st_q[0]) && $stable(st_q[1]) && $stable(st_q[2]) && $stable(st_q[3]))

endmodule
